[hdl/utr_pkg.sv]
// Shared types, constants and register codes for the up/down reload timer.
`timescale 1ns / 1ps

package utr_pkg;

	// Default sizes handed to the top-level parameters
	localparam int COUNTER_WIDTH_DEF = 32;
	localparam int NUM_CHANNELS_DEF  = 4;

	// Fixed field and bus widths
	localparam int TICK_W = 16;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int MAX_CH = 4;

	// Register index, paddr[4:2]
	typedef enum logic [2:0] {
		REG_AUTO_RELOAD    = 3'd0,
		REG_COUNT_DOWN     = 3'd1,
		REG_TIMER_ENABLE   = 3'd2,
		REG_COMPARE_1      = 3'd3,
		REG_COMPARE_2      = 3'd4,
		REG_COMPARE_3      = 3'd5,
		REG_COMPARE_4      = 3'd6,
		REG_COMPARE_ENABLE = 3'd7
	} reg_idx_t;

	// Configuration seen by the datapath
	typedef struct packed {
		logic [DATA_W-1:0]             auto_reload;
		logic                          count_down;
		logic                          timer_enable;
		logic [MAX_CH-1:0][DATA_W-1:0] compare_value;
		logic [MAX_CH-1:0]             compare_enable;
	} cfg_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic eval;
		logic div_step;
		logic commit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_div;
	} status_t;

endpackage

[hdl/utr_regs.sv]
// APB configuration register file of the up/down reload timer.
`timescale 1ns / 1ps

module utr_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [utr_pkg::ADDR_W-1:0]  paddr,
	input  logic [utr_pkg::DATA_W-1:0]  pwdata,
	output logic [utr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output utr_pkg::cfg_t               cfg
);

	utr_pkg::cfg_t     cfg_q;
	utr_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = utr_pkg::reg_idx_t'(paddr[utr_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_reload    <= '1;
			cfg_q.count_down     <= 1'b0;
			cfg_q.timer_enable   <= 1'b0;
			cfg_q.compare_value  <= '0;
			cfg_q.compare_enable <= '0;
		end else if (wr_en) begin
			case (idx)
				utr_pkg::REG_AUTO_RELOAD:    cfg_q.auto_reload      <= pwdata;
				utr_pkg::REG_COUNT_DOWN:     cfg_q.count_down       <= pwdata[0];
				utr_pkg::REG_TIMER_ENABLE:   cfg_q.timer_enable     <= pwdata[0];
				utr_pkg::REG_COMPARE_1:      cfg_q.compare_value[0] <= pwdata;
				utr_pkg::REG_COMPARE_2:      cfg_q.compare_value[1] <= pwdata;
				utr_pkg::REG_COMPARE_3:      cfg_q.compare_value[2] <= pwdata;
				utr_pkg::REG_COMPARE_4:      cfg_q.compare_value[3] <= pwdata;
				utr_pkg::REG_COMPARE_ENABLE:
					cfg_q.compare_enable <= pwdata[utr_pkg::MAX_CH-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (idx)
			utr_pkg::REG_AUTO_RELOAD:    prdata = cfg_q.auto_reload;
			utr_pkg::REG_COUNT_DOWN:     prdata[0] = cfg_q.count_down;
			utr_pkg::REG_TIMER_ENABLE:   prdata[0] = cfg_q.timer_enable;
			utr_pkg::REG_COMPARE_1:      prdata = cfg_q.compare_value[0];
			utr_pkg::REG_COMPARE_2:      prdata = cfg_q.compare_value[1];
			utr_pkg::REG_COMPARE_3:      prdata = cfg_q.compare_value[2];
			utr_pkg::REG_COMPARE_4:      prdata = cfg_q.compare_value[3];
			utr_pkg::REG_COMPARE_ENABLE:
				prdata[utr_pkg::MAX_CH-1:0] = cfg_q.compare_enable;
			default: prdata = '0;
		endcase
	end

endmodule

[hdl/utr_ctrl.sv]
// Sequencing state machine of the up/down reload timer.
`timescale 1ns / 1ps

module utr_ctrl #(
	parameter int COUNTER_WIDTH = utr_pkg::COUNTER_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output utr_pkg::cmd_t    cmd,
	input  utr_pkg::status_t status
);

	localparam int IT_W = $clog2(COUNTER_WIDTH + 1);
	localparam logic [IT_W-1:0] IT_LAST = IT_W'(COUNTER_WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_COMMIT
	} state_t;

	state_t          state_q;
	logic [IT_W-1:0] it_q;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.eval     = (state_q == ST_EVAL);
		cmd.div_step = (state_q == ST_DIV);
		cmd.commit   = (state_q == ST_COMMIT) && out_free;
	end

	// state, iteration count and result-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			it_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					it_q <= '0;
					state_q <= status.need_div ? ST_DIV : ST_COMMIT;
				end
				ST_DIV: begin
					it_q <= it_q + 1'b1;
					if (it_q == IT_LAST) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a committed result is offered in the next cycle
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("result not offered after commit");

	// remainder unit never runs past its last bit
	a_it_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> it_q <= IT_LAST)
		else $error("division iteration overrun");

	// last iteration leads to commit
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && it_q == IT_LAST) |=> state_q == ST_COMMIT)
		else $error("division did not finish");

endmodule

[hdl/utr_dp.sv]
// Counter, remainder unit, statistics and compare channels of the timer.
`timescale 1ns / 1ps

module utr_dp #(
	parameter int COUNTER_WIDTH = utr_pkg::COUNTER_WIDTH_DEF,
	parameter int NUM_CHANNELS  = utr_pkg::NUM_CHANNELS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  utr_pkg::cfg_t              cfg,
	input  utr_pkg::cmd_t              cmd,
	output utr_pkg::status_t           status,
	input  logic [utr_pkg::TICK_W-1:0] tick_count,
	output logic [utr_pkg::DATA_W-1:0] count_out,
	output logic                       wrapped,
	output logic [NUM_CHANNELS-1:0]    mask,
	output logic [utr_pkg::DATA_W-1:0] wraps_out,
	output logic [utr_pkg::DATA_W-1:0] max_out,
	output logic [utr_pkg::DATA_W-1:0] min_out,
	output logic [utr_pkg::DATA_W-1:0] tally [NUM_CHANNELS]
);

	localparam int W  = COUNTER_WIDTH;
	localparam int WP = COUNTER_WIDTH + 1;
	localparam int WS = COUNTER_WIDTH + 2;
	localparam int DW = utr_pkg::DATA_W;

	// item and step registers
	logic [utr_pkg::TICK_W-1:0] tick_q;
	logic [W-1:0]               top_q;
	logic [W-1:0]               nowrap_q;
	logic                       move_q;
	logic                       wrap_q;
	logic                       down_q;
	logic [W:0]                 rem_q;
	logic [W:0]                 dvd_q;

	// architectural state
	logic [W-1:0]              counter_q;
	logic [DW-1:0]             wrap_tally_q;
	logic [DW-1:0]             max_q;
	logic [DW-1:0]             min_q;
	logic [DW-1:0]             tally_q [NUM_CHANNELS];
	logic                      wrapped_q;
	logic [NUM_CHANNELS-1:0]   mask_q;

	// step evaluation
	logic [W-1:0] top;
	logic [W:0]   ticks_ext;
	logic [W:0]   cnt_ext;
	logic [W:0]   sum;
	logic [W:0]   diff;
	logic [W:0]   deficit;
	logic         up_wrap;
	logic         dn_wrap;
	logic         move;
	logic         wrap;

	assign top       = cfg.auto_reload[W-1:0];
	assign ticks_ext = WP'(tick_q);
	assign cnt_ext   = {1'b0, counter_q};
	assign sum       = cnt_ext + ticks_ext;
	assign diff      = cnt_ext - ticks_ext;
	assign deficit   = ticks_ext - cnt_ext - WP'(1);
	assign up_wrap   = sum > {1'b0, top};
	assign dn_wrap   = cnt_ext < ticks_ext;
	assign move      = cfg.timer_enable && (tick_q != '0);
	assign wrap      = cfg.count_down ? dn_wrap : up_wrap;
	assign status.need_div = move && wrap;

	// restoring remainder step, one dividend bit per cycle
	logic [W:0]    period;
	logic [WS-1:0] rem_sh;
	logic [WS-1:0] rem_sub;
	logic          rem_ge;

	assign period  = {1'b0, top_q} + WP'(1);
	assign rem_sh  = {rem_q, dvd_q[W]};
	assign rem_ge  = rem_sh >= {1'b0, period};
	assign rem_sub = rem_sh - {1'b0, period};

	// new counter value at commit
	logic [W-1:0]            rem_lo;
	logic [W-1:0]            new_cnt;
	logic [DW-1:0]           new_ext;
	logic [NUM_CHANNELS-1:0] match;

	assign rem_lo  = rem_q[W-1:0];
	assign new_cnt = !wrap_q ? nowrap_q : (down_q ? (top_q - rem_lo) : rem_lo);
	assign new_ext = DW'(new_cnt);

	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			match[i] = cfg.compare_enable[i] &&
				(new_cnt == cfg.compare_value[i][W-1:0]);
		end
	end

	// input capture, evaluation and divider registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tick_q <= tick_count;
		end
		if (cmd.eval) begin
			move_q   <= move;
			wrap_q   <= wrap;
			down_q   <= cfg.count_down;
			top_q    <= top;
			nowrap_q <= cfg.count_down ? diff[W-1:0] : sum[W-1:0];
			dvd_q    <= cfg.count_down ? deficit : sum;
			rem_q    <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[W:0] : rem_sh[W:0];
			dvd_q <= {dvd_q[W-1:0], 1'b0};
		end
	end

	// state update on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q    <= '0;
			wrap_tally_q <= '0;
			max_q        <= '0;
			min_q        <= '1;
			wrapped_q    <= 1'b0;
			mask_q       <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				tally_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			wrapped_q <= move_q && wrap_q;
			mask_q    <= move_q ? match : '0;
			if (move_q) begin
				counter_q <= new_cnt;
				if (wrap_q) begin
					wrap_tally_q <= wrap_tally_q + DW'(1);
				end
				if (new_ext > max_q) begin
					max_q <= new_ext;
				end
				if (new_ext < min_q) begin
					min_q <= new_ext;
				end
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					if (match[i]) begin
						tally_q[i] <= tally_q[i] + DW'(1);
					end
				end
			end
		end
	end

	// state registers double as the result registers
	assign count_out = DW'(counter_q);
	assign wrapped   = wrapped_q;
	assign mask      = mask_q;
	assign wraps_out = wrap_tally_q;
	assign max_out   = max_q;
	assign min_out   = min_q;
	always_comb begin
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			tally[i] = tally_q[i];
		end
	end

	// partial remainder stays reduced below the period
	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q <= {1'b0, top_q})
		else $error("remainder not reduced");

	// a wrapping step adds exactly one to the wrap tally
	a_wrap_once: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && move_q && wrap_q) |=>
			wrap_tally_q == $past(wrap_tally_q) + DW'(1))
		else $error("wrap tally not advanced by one");

	// after any moving step the extremes are ordered
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && move_q) |=> min_q <= max_q)
		else $error("min above max after a step");

endmodule

[hdl/up_down_reload_timer.sv]
// Top level of the up/down timer with auto-reload and compare channels.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    tick_count
//   out      from block out_valid / out_stall  count_out, wrapped, match_mask, wraps_out,
//                                              max_out, min_out, match_count_1..4
//   cfg      to block   psel/penable/pwrite    paddr, pwdata, prdata (pready always high)
//
// A step that does not wrap passes through the idle, evaluate and commit states;
// a wrapping step also runs the divide state, where the remainder unit
// retires one dividend bit per cycle over the COUNTER_WIDTH+1 dividend bits.
// Reset (arst_n low) loads the register and state reset values at once.
// A result waits in the state registers; the next item is accepted while it
// waits, and a held result only stalls the commit of the following item.
`timescale 1ns / 1ps

module up_down_reload_timer #(
	parameter int COUNTER_WIDTH = utr_pkg::COUNTER_WIDTH_DEF,
	parameter int NUM_CHANNELS  = utr_pkg::NUM_CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [utr_pkg::ADDR_W-1:0]  paddr,
	input  logic [utr_pkg::DATA_W-1:0]  pwdata,
	output logic [utr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	// input items
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [utr_pkg::TICK_W-1:0]  tick_count,
	// result items
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [utr_pkg::DATA_W-1:0]  count_out,
	output logic                        wrapped,
	output logic [utr_pkg::MAX_CH-1:0]  match_mask,
	output logic [utr_pkg::DATA_W-1:0]  wraps_out,
	output logic [utr_pkg::DATA_W-1:0]  max_out,
	output logic [utr_pkg::DATA_W-1:0]  min_out,
	output logic [utr_pkg::DATA_W-1:0]  match_count_1,
	output logic [utr_pkg::DATA_W-1:0]  match_count_2,
	output logic [utr_pkg::DATA_W-1:0]  match_count_3,
	output logic [utr_pkg::DATA_W-1:0]  match_count_4
);

	localparam int MC = utr_pkg::MAX_CH;

	utr_pkg::cfg_t             cfg;
	utr_pkg::cmd_t             cmd;
	utr_pkg::status_t          status;
	logic [NUM_CHANNELS-1:0]   mask;
	logic [utr_pkg::DATA_W-1:0] tally [NUM_CHANNELS];
	logic [utr_pkg::DATA_W-1:0] tally_all [MC];

	utr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	utr_ctrl #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	utr_dp #(
		.COUNTER_WIDTH (COUNTER_WIDTH),
		.NUM_CHANNELS  (NUM_CHANNELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.cmd        (cmd),
		.status     (status),
		.tick_count (tick_count),
		.count_out  (count_out),
		.wrapped    (wrapped),
		.mask       (mask),
		.wraps_out  (wraps_out),
		.max_out    (max_out),
		.min_out    (min_out),
		.tally      (tally)
	);

	// unused channels read zero
	always_comb begin
		for (int i = 0; i < MC; i++) begin
			tally_all[i] = '0;
		end
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			tally_all[i] = tally[i];
		end
	end

	assign match_mask    = MC'(mask);
	assign match_count_1 = tally_all[0];
	assign match_count_2 = tally_all[1];
	assign match_count_3 = tally_all[2];
	assign match_count_4 = tally_all[3];

endmodule
